// ===== hw/rtl/tqc_pkg.sv =====
// shared types, sizes and codes for the two-queue cache policy unit
// used by tqc_tags, tqc_ghost, the top level and the checker
package tqc_pkg;

	localparam int ENTRIES       = 32;
	localparam int GHOST_ENTRIES = 32;

	localparam int KEY_W   = 64;
	localparam int SIZE_W  = 32;
	localparam int KIND_W  = 16;
	localparam int CAP_W   = 40;
	localparam int GMAX_W  = 6;
	localparam int USED_W  = 41;
	localparam int SUM_W   = USED_W + 2;
	localparam int CFG_W   = 40;
	localparam int CIDX_W  = 1;

	localparam int SLOT_W  = $clog2(ENTRIES);
	localparam int CNT_W   = $clog2(ENTRIES + 1);
	localparam int GIDX_W  = (GHOST_ENTRIES > 1) ? $clog2(GHOST_ENTRIES) : 1;
	localparam int GCNT_W  = $clog2(GHOST_ENTRIES + 1);
	localparam int GCMP_W  = (GCNT_W + 1 > GMAX_W) ? GCNT_W + 1 : GMAX_W;
	localparam int SCAN_MAX = (ENTRIES > GHOST_ENTRIES) ? ENTRIES : GHOST_ENTRIES;
	localparam int SCAN_W  = $clog2(SCAN_MAX + 1);

	typedef enum logic [1:0] {
		OP_LOOKUP = 2'd0,
		OP_PEEK   = 2'd1,
		OP_INSERT = 2'd2,
		OP_ERASE  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		HIT_MISS  = 2'd0,
		HIT_A1IN  = 2'd1,
		HIT_AM    = 2'd2,
		HIT_GHOST = 2'd3
	} hit_t;

	localparam logic RK_FINAL = 1'b0;
	localparam logic RK_EVICT = 1'b1;

	localparam logic [CIDX_W-1:0] REG_CAPACITY  = 1'd0;
	localparam logic [CIDX_W-1:0] REG_GHOST_MAX = 1'd1;

	localparam logic [CAP_W-1:0]  CAP_RESET  = 40'd1048576;
	localparam logic [GMAX_W-1:0] GMAX_RESET = 6'd32;

	// one tag store slot as seen on the read side
	typedef struct packed {
		logic              valid;
		logic              in_am;
		logic [SLOT_W-1:0] rank;
		logic [KEY_W-1:0]  key;
		logic [SIZE_W-1:0] size;
		logic [KIND_W-1:0] kind;
	} slot_t;

	// operation on the addressed slot
	typedef struct packed {
		logic              admit;
		logic              remove;
		logic              touch;
		logic              resize;
		logic              to_am;
		logic [KEY_W-1:0]  key;
		logic [SIZE_W-1:0] size;
		logic [KIND_W-1:0] kind;
	} tag_cmd_t;

endpackage

// ===== hw/rtl/tqc_tags.sv =====
// resident tag store: keys, sizes, kinds, queue bit and list rank per slot
// depends on tqc_pkg
module tqc_tags (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [tqc_pkg::SLOT_W-1:0] idx,
	input  tqc_pkg::tag_cmd_t          cmd,
	output tqc_pkg::slot_t             rd
);

	logic                       valid_q [tqc_pkg::ENTRIES];
	logic                       in_am_q [tqc_pkg::ENTRIES];
	logic [tqc_pkg::SLOT_W-1:0] rank_q  [tqc_pkg::ENTRIES];
	logic [tqc_pkg::KEY_W-1:0]  key_q   [tqc_pkg::ENTRIES];
	logic [tqc_pkg::SIZE_W-1:0] size_q  [tqc_pkg::ENTRIES];
	logic [tqc_pkg::KIND_W-1:0] kind_q  [tqc_pkg::ENTRIES];

	logic                       sel_q;
	logic [tqc_pkg::SLOT_W-1:0] sel_rank;

	assign rd.valid = valid_q[idx];
	assign rd.in_am = in_am_q[idx];
	assign rd.rank  = rank_q[idx];
	assign rd.key   = key_q[idx];
	assign rd.size  = size_q[idx];
	assign rd.kind  = kind_q[idx];

	// queue whose ranks move, and the rank of the addressed slot
	assign sel_q    = cmd.admit ? cmd.to_am : in_am_q[idx];
	assign sel_rank = rank_q[idx];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < tqc_pkg::ENTRIES; j++) begin
				valid_q[j] <= 1'b0;
				in_am_q[j] <= 1'b0;
				rank_q[j]  <= '0;
			end
		end else begin
			for (int j = 0; j < tqc_pkg::ENTRIES; j++) begin
				if (idx == tqc_pkg::SLOT_W'(j)) begin
					if (cmd.admit) begin
						valid_q[j] <= 1'b1;
						in_am_q[j] <= cmd.to_am;
						rank_q[j]  <= '0;
					end else if (cmd.remove) begin
						valid_q[j] <= 1'b0;
						in_am_q[j] <= 1'b0;
					end else if (cmd.touch) begin
						rank_q[j] <= '0;
					end
				end else if (valid_q[j] && in_am_q[j] == sel_q) begin
					// neighbors in the same list shift by one place
					if (cmd.admit) begin
						rank_q[j] <= rank_q[j] + 1'b1;
					end else if (cmd.remove && rank_q[j] > sel_rank) begin
						rank_q[j] <= rank_q[j] - 1'b1;
					end else if (cmd.touch && rank_q[j] < sel_rank) begin
						rank_q[j] <= rank_q[j] + 1'b1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.admit) begin
			key_q[idx]  <= cmd.key;
			size_q[idx] <= cmd.size;
			kind_q[idx] <= cmd.kind;
		end else if (cmd.resize) begin
			size_q[idx] <= cmd.size;
			kind_q[idx] <= cmd.kind;
		end
	end

endmodule

// ===== hw/rtl/tqc_ghost.sv =====
// ghost fifo of keys evicted from a1in, newest at position zero
// depends on tqc_pkg
module tqc_ghost (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [tqc_pkg::GIDX_W-1:0] idx,
	input  logic                       push,
	input  logic [tqc_pkg::KEY_W-1:0]  push_key,
	input  logic                       drop,
	input  logic [tqc_pkg::GMAX_W-1:0] gmax,
	output logic [tqc_pkg::KEY_W-1:0]  rd_key,
	output logic [tqc_pkg::GCNT_W-1:0] count
);

	logic [tqc_pkg::KEY_W-1:0]  keys_q [tqc_pkg::GHOST_ENTRIES];
	logic [tqc_pkg::GCNT_W-1:0] count_q;
	logic [tqc_pkg::GCMP_W-1:0] kept;
	logic [tqc_pkg::GCMP_W-1:0] grown;

	assign rd_key = keys_q[idx];
	assign count  = count_q;

	// oldest key falls off when full, then the limit trims the count
	assign kept  = (count_q >= tqc_pkg::GCNT_W'(tqc_pkg::GHOST_ENTRIES))
		? tqc_pkg::GCMP_W'(tqc_pkg::GHOST_ENTRIES - 1) : tqc_pkg::GCMP_W'(count_q);
	assign grown = kept + 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (push) begin
			count_q <= (grown > tqc_pkg::GCMP_W'(gmax))
				? tqc_pkg::GCNT_W'(gmax) : tqc_pkg::GCNT_W'(grown);
		end else if (drop) begin
			count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			for (int j = tqc_pkg::GHOST_ENTRIES - 1; j > 0; j--) begin
				keys_q[j] <= keys_q[j-1];
			end
			keys_q[0] <= push_key;
		end else if (drop) begin
			for (int j = 0; j < tqc_pkg::GHOST_ENTRIES - 1; j++) begin
				if (tqc_pkg::GIDX_W'(j) >= idx) begin
					keys_q[j] <= keys_q[j+1];
				end
			end
		end
	end

endmodule

// ===== hw/rtl/two_queue_cache_policy_unit.sv =====
// top level of the two-queue cache policy unit: sequencer, scan counter,
// byte accounting and output register; uses tqc_pkg, tqc_tags, tqc_ghost
//
// usage
// - input channel in_valid/in_stall carries one item: opcode, key, size_bytes,
//   item_kind; it is taken when in_valid is high and in_stall is low
// - output channel out_valid/out_stall carries result items; every item gives
//   zero or more eviction notices followed by one final answer with last set
// - cfg_wr_en/cfg_index/cfg_data write the byte capacity (0) and ghost_max (1);
//   write only while no item is in flight
// - one shared key comparator and one scan counter walk the tag store a slot
//   per cycle; a miss walks all ENTRIES slots
// - a lookup, erase or insert miss then walks the ghost keys held; a new
//   insert then walks for the lowest free slot; a peek miss walks no further
// - each eviction adds a tail walk of up to ENTRIES slots
// - in_stall stays high for the whole item; the next item is taken in the cycle
//   after the final answer is loaded, while that answer waits for the receiver
// - a stalled receiver holds a result in place; the walk waits for it
// - reset empties both lists and the ghost queue, clears byte counts and
//   loads capacity 1048576 and ghost limit 32; no clearing pass is needed
module two_queue_cache_policy_unit (
	input  logic                        clk,
	input  logic                        arst_n,
	// configuration
	input  logic                        cfg_wr_en,
	input  logic [tqc_pkg::CIDX_W-1:0]  cfg_index,
	input  logic [tqc_pkg::CFG_W-1:0]   cfg_data,
	// input items
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [1:0]                  opcode,
	input  logic [tqc_pkg::KEY_W-1:0]   key,
	input  logic [tqc_pkg::SIZE_W-1:0]  size_bytes,
	input  logic [tqc_pkg::KIND_W-1:0]  item_kind,
	// result items
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic                        result_kind,
	output logic [1:0]                  hit_where,
	output logic                        success,
	output logic [tqc_pkg::SIZE_W-1:0]  entry_size,
	output logic [tqc_pkg::KIND_W-1:0]  entry_kind,
	output logic [tqc_pkg::KEY_W-1:0]   victim_key,
	output logic                        last
);

	typedef enum logic [12:0] {
		S_IDLE  = 13'b0000000000001,
		S_FIND  = 13'b0000000000010,  // walk tag store for the key
		S_HIT   = 13'b0000000000100,
		S_MISS  = 13'b0000000001000,
		S_GFIND = 13'b0000000010000,  // walk ghost queue for the key
		S_GDONE = 13'b0000000100000,
		S_TRIM  = 13'b0000001000000,  // a1in over its quarter budget
		S_FIT   = 13'b0000010000000,  // total over budget or store full
		S_TAIL  = 13'b0000100000000,  // walk for the tail of a list
		S_EVICT = 13'b0001000000000,
		S_FREE  = 13'b0010000000000,  // walk for a free slot
		S_ADMIT = 13'b0100000000000,
		S_EMIT  = 13'b1000000000000   // hand staged result to output
	} state_t;

	state_t                       state_q, ret_q;
	logic [tqc_pkg::SCAN_W-1:0]   idx_q;
	logic [tqc_pkg::SLOT_W-1:0]   slot_q;
	logic [tqc_pkg::GIDX_W-1:0]   gidx_q;
	logic                         ghit_q;
	logic                         to_am_q;
	logic                         tgt_am_q;
	logic                         in_trim_q;
	logic                         need_slot_q;
	logic [tqc_pkg::SIZE_W-1:0]   inc_q;

	tqc_pkg::op_t                 op_q;
	logic [tqc_pkg::KEY_W-1:0]    key_q;
	logic [tqc_pkg::SIZE_W-1:0]   size_q;
	logic [tqc_pkg::KIND_W-1:0]   kind_q;

	logic [tqc_pkg::CAP_W-1:0]    cap_q;
	logic [tqc_pkg::GMAX_W-1:0]   gmax_q;
	logic [tqc_pkg::CNT_W-1:0]    a1in_n_q, am_n_q;
	logic [tqc_pkg::USED_W-1:0]   a1in_used_q, am_used_q;

	// staged result
	logic                         st_rk_q;
	logic [1:0]                   st_where_q;
	logic                         st_succ_q;
	logic [tqc_pkg::SIZE_W-1:0]   st_size_q;
	logic [tqc_pkg::KIND_W-1:0]   st_kind_q;
	logic [tqc_pkg::KEY_W-1:0]    st_evk_q;

	// output register
	logic                         out_valid_q;
	logic                         out_rk_q;
	logic [1:0]                   out_where_q;
	logic                         out_succ_q;
	logic [tqc_pkg::SIZE_W-1:0]   out_size_q;
	logic [tqc_pkg::KIND_W-1:0]   out_kind_q;
	logic [tqc_pkg::KEY_W-1:0]    out_evk_q;
	logic                         out_last_q;

	logic [tqc_pkg::SLOT_W-1:0]   tag_idx;
	tqc_pkg::tag_cmd_t            tag_cmd;
	tqc_pkg::slot_t               slot;
	logic [tqc_pkg::GIDX_W-1:0]   g_idx;
	logic                         g_push, g_drop;
	logic [tqc_pkg::KEY_W-1:0]    g_key;
	logic [tqc_pkg::GCNT_W-1:0]   g_count;

	logic                         in_take;
	logic                         out_free;
	logic                         emit_go;
	logic                         key_hit;
	logic                         ghost_key_hit;
	logic [tqc_pkg::SUM_W-1:0]    a1in_plus;
	logic [tqc_pkg::SUM_W-1:0]    total_plus;
	logic                         trim_over;
	logic                         fit_over;
	logic [tqc_pkg::CNT_W:0]      resident_n;
	logic                         store_full;
	logic [tqc_pkg::CNT_W-1:0]    tgt_n;
	logic                         tail_hit;
	logic                         scan_end;

	tqc_tags u_tags (
		.clk    (clk),
		.arst_n (arst_n),
		.idx    (tag_idx),
		.cmd    (tag_cmd),
		.rd     (slot)
	);

	tqc_ghost u_ghost (
		.clk      (clk),
		.arst_n   (arst_n),
		.idx      (g_idx),
		.push     (g_push),
		.push_key (slot.key),
		.drop     (g_drop),
		.gmax     (gmax_q),
		.rd_key   (g_key),
		.count    (g_count)
	);

	assign in_stall = (state_q != S_IDLE);
	assign in_take  = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;
	assign emit_go  = (state_q == S_EMIT) && out_free;

	// walks use the scan counter, everything else the latched slot
	assign tag_idx = (state_q == S_FIND || state_q == S_TAIL || state_q == S_FREE)
		? idx_q[tqc_pkg::SLOT_W-1:0] : slot_q;
	assign g_idx   = (state_q == S_GFIND) ? idx_q[tqc_pkg::GIDX_W-1:0] : gidx_q;

	// the shared key comparator
	assign key_hit       = slot.valid && (slot.key == key_q);
	assign ghost_key_hit = (g_key == key_q);
	assign scan_end      = (idx_q == tqc_pkg::SCAN_W'(tqc_pkg::ENTRIES - 1));

	// budget checks
	assign a1in_plus  = tqc_pkg::SUM_W'(a1in_used_q) + tqc_pkg::SUM_W'(inc_q);
	assign total_plus = tqc_pkg::SUM_W'(a1in_used_q) + tqc_pkg::SUM_W'(am_used_q)
		+ tqc_pkg::SUM_W'(inc_q);
	assign trim_over  = (a1in_n_q != '0)
		&& (a1in_plus > tqc_pkg::SUM_W'(cap_q[tqc_pkg::CAP_W-1:2]));
	assign fit_over   = total_plus > tqc_pkg::SUM_W'(cap_q);
	assign resident_n = (tqc_pkg::CNT_W+1)'(a1in_n_q) + (tqc_pkg::CNT_W+1)'(am_n_q);
	assign store_full = need_slot_q
		&& (resident_n >= (tqc_pkg::CNT_W+1)'(tqc_pkg::ENTRIES));

	// tail of a list is the valid slot of that queue with the highest rank
	assign tgt_n    = tgt_am_q ? am_n_q : a1in_n_q;
	assign tail_hit = slot.valid && (slot.in_am == tgt_am_q)
		&& (slot.rank == tqc_pkg::SLOT_W'(tgt_n - 1'b1));

	always_comb begin
		tag_cmd       = '0;
		tag_cmd.to_am = to_am_q;
		tag_cmd.key   = key_q;
		tag_cmd.size  = size_q;
		tag_cmd.kind  = kind_q;
		case (state_q)
			S_HIT: begin
				case (op_q)
					tqc_pkg::OP_LOOKUP: tag_cmd.touch  = slot.in_am;
					tqc_pkg::OP_INSERT: tag_cmd.resize = 1'b1;
					tqc_pkg::OP_ERASE:  tag_cmd.remove = 1'b1;
					default:            tag_cmd.touch  = 1'b0;
				endcase
			end
			S_EVICT: tag_cmd.remove = 1'b1;
			S_ADMIT: tag_cmd.admit  = 1'b1;
			default: tag_cmd.admit  = 1'b0;
		endcase
	end

	// an a1in eviction feeds the ghost queue
	assign g_push = (state_q == S_EVICT) && !tgt_am_q;
	assign g_drop = (state_q == S_GDONE) && ghit_q
		&& (op_q == tqc_pkg::OP_INSERT || op_q == tqc_pkg::OP_ERASE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			ret_q       <= S_IDLE;
			idx_q       <= '0;
			slot_q      <= '0;
			gidx_q      <= '0;
			ghit_q      <= 1'b0;
			to_am_q     <= 1'b0;
			tgt_am_q    <= 1'b0;
			in_trim_q   <= 1'b0;
			need_slot_q <= 1'b0;
			inc_q       <= '0;
			op_q        <= tqc_pkg::OP_LOOKUP;
			key_q       <= '0;
			size_q      <= '0;
			kind_q      <= '0;
			cap_q       <= tqc_pkg::CAP_RESET;
			gmax_q      <= tqc_pkg::GMAX_RESET;
			a1in_n_q    <= '0;
			am_n_q      <= '0;
			a1in_used_q <= '0;
			am_used_q   <= '0;
			st_rk_q     <= tqc_pkg::RK_FINAL;
			st_where_q  <= tqc_pkg::HIT_MISS;
			st_succ_q   <= 1'b0;
			st_size_q   <= '0;
			st_kind_q   <= '0;
			st_evk_q    <= '0;
			out_valid_q <= 1'b0;
			out_rk_q    <= tqc_pkg::RK_FINAL;
			out_where_q <= tqc_pkg::HIT_MISS;
			out_succ_q  <= 1'b0;
			out_size_q  <= '0;
			out_kind_q  <= '0;
			out_evk_q   <= '0;
			out_last_q  <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				case (cfg_index)
					tqc_pkg::REG_CAPACITY:  cap_q  <= cfg_data[tqc_pkg::CAP_W-1:0];
					tqc_pkg::REG_GHOST_MAX: gmax_q <= cfg_data[tqc_pkg::GMAX_W-1:0];
					default:                cap_q  <= cap_q;
				endcase
			end

			// a new result replaces the one just taken, else the register empties
			if (emit_go) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				S_IDLE: begin
					if (in_take) begin
						op_q    <= tqc_pkg::op_t'(opcode);
						key_q   <= key;
						size_q  <= size_bytes;
						kind_q  <= item_kind;
						idx_q   <= '0;
						ghit_q  <= 1'b0;
						to_am_q <= 1'b0;
						state_q <= S_FIND;
					end
				end
				S_FIND: begin
					if (key_hit) begin
						slot_q  <= idx_q[tqc_pkg::SLOT_W-1:0];
						state_q <= S_HIT;
					end else if (scan_end) begin
						state_q <= S_MISS;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				S_HIT: begin
					case (op_q)
						tqc_pkg::OP_LOOKUP, tqc_pkg::OP_PEEK: begin
							st_rk_q    <= tqc_pkg::RK_FINAL;
							st_where_q <= slot.in_am ? tqc_pkg::HIT_AM : tqc_pkg::HIT_A1IN;
							st_succ_q  <= 1'b0;
							st_size_q  <= slot.size;
							st_kind_q  <= slot.kind;
							st_evk_q   <= '0;
							ret_q      <= S_IDLE;
							state_q    <= S_EMIT;
						end
						tqc_pkg::OP_INSERT: begin
							// replace in place, then fit with nothing incoming
							if (slot.in_am) begin
								am_used_q <= am_used_q - tqc_pkg::USED_W'(slot.size)
									+ tqc_pkg::USED_W'(size_q);
							end else begin
								a1in_used_q <= a1in_used_q - tqc_pkg::USED_W'(slot.size)
									+ tqc_pkg::USED_W'(size_q);
							end
							inc_q       <= '0;
							need_slot_q <= 1'b0;
							state_q     <= S_TRIM;
						end
						default: begin
							if (slot.in_am) begin
								am_used_q <= am_used_q - tqc_pkg::USED_W'(slot.size);
								am_n_q    <= am_n_q - 1'b1;
							end else begin
								a1in_used_q <= a1in_used_q - tqc_pkg::USED_W'(slot.size);
								a1in_n_q    <= a1in_n_q - 1'b1;
							end
							st_rk_q    <= tqc_pkg::RK_FINAL;
							st_where_q <= tqc_pkg::HIT_MISS;
							st_succ_q  <= 1'b1;
							st_size_q  <= '0;
							st_kind_q  <= '0;
							st_evk_q   <= '0;
							ret_q      <= S_IDLE;
							state_q    <= S_EMIT;
						end
					endcase
				end
				S_MISS: begin
					st_rk_q    <= tqc_pkg::RK_FINAL;
					st_where_q <= tqc_pkg::HIT_MISS;
					st_succ_q  <= 1'b0;
					st_size_q  <= '0;
					st_kind_q  <= '0;
					st_evk_q   <= '0;
					idx_q      <= '0;
					if (op_q == tqc_pkg::OP_PEEK) begin
						// peek never looks at the ghost queue
						ret_q   <= S_IDLE;
						state_q <= S_EMIT;
					end else begin
						state_q <= S_GFIND;
					end
				end
				S_GFIND: begin
					if (idx_q >= tqc_pkg::SCAN_W'(g_count)) begin
						state_q <= S_GDONE;
					end else if (ghost_key_hit) begin
						gidx_q  <= idx_q[tqc_pkg::GIDX_W-1:0];
						ghit_q  <= 1'b1;
						state_q <= S_GDONE;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				S_GDONE: begin
					case (op_q)
						tqc_pkg::OP_INSERT: begin
							to_am_q     <= ghit_q;
							inc_q       <= size_q;
							need_slot_q <= 1'b1;
							state_q     <= S_TRIM;
						end
						tqc_pkg::OP_ERASE: begin
							st_succ_q <= ghit_q;
							ret_q     <= S_IDLE;
							state_q   <= S_EMIT;
						end
						default: begin
							st_where_q <= ghit_q ? tqc_pkg::HIT_GHOST : tqc_pkg::HIT_MISS;
							ret_q      <= S_IDLE;
							state_q    <= S_EMIT;
						end
					endcase
				end
				S_TRIM: begin
					idx_q <= '0;
					if (trim_over) begin
						tgt_am_q  <= 1'b0;
						in_trim_q <= 1'b1;
						state_q   <= S_TAIL;
					end else begin
						state_q <= S_FIT;
					end
				end
				S_FIT: begin
					idx_q     <= '0;
					in_trim_q <= 1'b0;
					if ((fit_over || store_full) && am_n_q != '0) begin
						tgt_am_q <= 1'b1;
						state_q  <= S_TAIL;
					end else if ((fit_over || store_full) && a1in_n_q != '0) begin
						tgt_am_q <= 1'b0;
						state_q  <= S_TAIL;
					end else if (need_slot_q) begin
						state_q <= S_FREE;
					end else begin
						st_rk_q    <= tqc_pkg::RK_FINAL;
						st_where_q <= tqc_pkg::HIT_MISS;
						st_succ_q  <= 1'b0;
						st_size_q  <= '0;
						st_kind_q  <= '0;
						st_evk_q   <= '0;
						ret_q      <= S_IDLE;
						state_q    <= S_EMIT;
					end
				end
				S_TAIL: begin
					if (tail_hit) begin
						slot_q  <= idx_q[tqc_pkg::SLOT_W-1:0];
						state_q <= S_EVICT;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				S_EVICT: begin
					if (tgt_am_q) begin
						am_used_q <= am_used_q - tqc_pkg::USED_W'(slot.size);
						am_n_q    <= am_n_q - 1'b1;
					end else begin
						a1in_used_q <= a1in_used_q - tqc_pkg::USED_W'(slot.size);
						a1in_n_q    <= a1in_n_q - 1'b1;
					end
					st_rk_q    <= tqc_pkg::RK_EVICT;
					st_where_q <= tqc_pkg::HIT_MISS;
					st_succ_q  <= 1'b0;
					st_size_q  <= '0;
					st_kind_q  <= '0;
					st_evk_q   <= slot.key;
					ret_q      <= in_trim_q ? S_TRIM : S_FIT;
					state_q    <= S_EMIT;
				end
				S_FREE: begin
					if (!slot.valid) begin
						slot_q  <= idx_q[tqc_pkg::SLOT_W-1:0];
						state_q <= S_ADMIT;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				S_ADMIT: begin
					if (to_am_q) begin
						am_used_q <= am_used_q + tqc_pkg::USED_W'(size_q);
						am_n_q    <= am_n_q + 1'b1;
					end else begin
						a1in_used_q <= a1in_used_q + tqc_pkg::USED_W'(size_q);
						a1in_n_q    <= a1in_n_q + 1'b1;
					end
					st_rk_q    <= tqc_pkg::RK_FINAL;
					st_where_q <= tqc_pkg::HIT_MISS;
					st_succ_q  <= 1'b0;
					st_size_q  <= '0;
					st_kind_q  <= '0;
					st_evk_q   <= '0;
					ret_q      <= S_IDLE;
					state_q    <= S_EMIT;
				end
				S_EMIT: begin
					if (out_free) begin
						out_rk_q    <= st_rk_q;
						out_where_q <= st_where_q;
						out_succ_q  <= st_succ_q;
						out_size_q  <= st_size_q;
						out_kind_q  <= st_kind_q;
						out_evk_q   <= st_evk_q;
						out_last_q  <= (st_rk_q == tqc_pkg::RK_FINAL);
						state_q     <= ret_q;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid   = out_valid_q;
	assign result_kind = out_rk_q;
	assign hit_where   = out_where_q;
	assign success     = out_succ_q;
	assign entry_size  = out_size_q;
	assign entry_kind  = out_kind_q;
	assign victim_key  = out_evk_q;
	assign last        = out_last_q;

endmodule

// ===== hw/rtl/tqc_checker.sv =====
// port-level checks for the two-queue cache policy unit, bound to the top
// depends on tqc_pkg
module tqc_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       in_valid,
	input logic                       in_stall,
	input logic                       out_valid,
	input logic                       out_stall,
	input logic                       result_kind,
	input logic [1:0]                 hit_where,
	input logic                       success,
	input logic [tqc_pkg::KEY_W-1:0]  victim_key,
	input logic                       last
);

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(victim_key) && $stable(last))
		else $error("stalled result changed");

	// last marks final answers only
	a_last_final: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (last == (result_kind == tqc_pkg::RK_FINAL)))
		else $error("last does not match result kind");

	// notices carry no hit or success
	a_notice_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && result_kind == tqc_pkg::RK_EVICT |-> hit_where == 2'd0 && !success)
		else $error("eviction notice with answer fields");

	// an accepted item closes the input
	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input open right after accept");

endmodule

bind two_queue_cache_policy_unit tqc_checker u_tqc_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_stall    (in_stall),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.result_kind (result_kind),
	.hit_where   (hit_where),
	.success     (success),
	.victim_key  (victim_key),
	.last        (last)
);
